/* design/hpack_pkg.sv */
// shared types, constants and code rom for the hpack huffman encoder
`default_nettype none
package hpack_pkg;

  localparam int SYM_W = 8;
  localparam int CODE_W = 30;
  localparam int LEN_W = 5;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              last;
  } hp_entry_t;

  localparam logic [CODE_W-1:0] CODE_ROM [256] = '{
    30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3, 30'hfffffe4, 30'hfffffe5, 30'hfffffe6,
    30'hfffffe7, 30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9, 30'hfffffea,
    30'h3ffffffd, 30'hfffffeb, 30'hfffffec, 30'hfffffed, 30'hfffffee, 30'hfffffef,
    30'hffffff0, 30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3, 30'hffffff4,
    30'hffffff5, 30'hffffff6, 30'hffffff7, 30'hffffff8, 30'hffffff9, 30'hffffffa,
    30'hffffffb, 30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
    30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17, 30'h18,
    30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
    30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
    30'h1ffa, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
    30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
    30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
    30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
    30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
    30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
    30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
    30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc,
    30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8, 30'h3fffd3, 30'h3fffd4, 30'h3fffd5,
    30'h7fffd9, 30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc, 30'h7fffdd, 30'h7fffde,
    30'hffffeb, 30'h7fffdf, 30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0, 30'hffffee,
    30'h7fffe1, 30'h7fffe2, 30'h7fffe3, 30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5,
    30'h3fffd9, 30'h7fffe6, 30'h7fffe7, 30'hffffef, 30'h3fffda, 30'h1fffdd, 30'hfffe9,
    30'h3fffdb, 30'h3fffdc, 30'h7fffe8, 30'h7fffe9, 30'h1fffde, 30'h7fffea, 30'h3fffdd,
    30'h3fffde, 30'hfffff0, 30'h1fffdf, 30'h3fffdf, 30'h7fffeb, 30'h7fffec, 30'h1fffe0,
    30'h1fffe1, 30'h3fffe0, 30'h1fffe2, 30'h7fffed, 30'h3fffe1, 30'h7fffee, 30'h7fffef,
    30'hfffea, 30'h3fffe2, 30'h3fffe3, 30'h3fffe4, 30'h7ffff0, 30'h3fffe5, 30'h3fffe6,
    30'h7ffff1, 30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1, 30'h3fffe7, 30'h7ffff2,
    30'h3fffe8, 30'h1ffffec, 30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde,
    30'h7ffffdf, 30'h3ffffe5, 30'hfffff1, 30'h1ffffed, 30'h7fff2, 30'h1fffe3, 30'h3ffffe6,
    30'h7ffffe0, 30'h7ffffe1, 30'h3ffffe7, 30'h7ffffe2, 30'hfffff2, 30'h1fffe4, 30'h1fffe5,
    30'h3ffffe8, 30'h3ffffe9, 30'hffffffd, 30'h7ffffe3, 30'h7ffffe4, 30'h7ffffe5,
    30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6, 30'h3fffe9, 30'h1fffe7, 30'h1fffe8,
    30'h7ffff3, 30'h3fffea, 30'h3fffeb, 30'h1ffffee, 30'h1ffffef, 30'hfffff4, 30'hfffff5,
    30'h3ffffea, 30'h7ffff4, 30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed,
    30'h7ffffe7, 30'h7ffffe8, 30'h7ffffe9, 30'h7ffffea, 30'h7ffffeb, 30'hffffffe,
    30'h7ffffec, 30'h7ffffed, 30'h7ffffee, 30'h7ffffef, 30'h7fffff0, 30'h3ffffee
  };

  localparam logic [LEN_W-1:0] LEN_ROM [256] = '{
    13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
    28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
    6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
    5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
    13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
    7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
    15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
    6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28,
    20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
    24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
    22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
    21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
    26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
    19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
    20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
    26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26
  };

endpackage
`default_nettype wire

/* design/hpack_front.sv */
// front end: code rom lookup into a small entry queue
`default_nettype none
module hpack_front
  import hpack_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [SYM_W-1:0] symbol,
  input  wire logic             last,
  output logic                  q_valid,
  input  wire logic             q_pop,
  output hp_entry_t             q_entry
);
  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  hp_entry_t          mem [QueueDepth];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    count;
  logic               push;
  logic               pop;
  hp_entry_t          new_entry;

  assign in_stall = (count == CntW'(QueueDepth));
  assign push = in_valid && !in_stall;
  assign pop = q_pop && q_valid;
  assign q_valid = (count != '0);
  assign q_entry = mem[rd_ptr];

  always_comb begin
    new_entry.code = CODE_ROM[symbol];
    new_entry.len = LEN_ROM[symbol];
    new_entry.last = last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end
endmodule
`default_nettype wire

/* design/hpack_back.sv */
// back end: bit accumulator that emits one byte per cycle unless the output stalls
`default_nettype none
module hpack_back
  import hpack_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  output logic            q_pop,
  input  wire hp_entry_t  q_entry,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  localparam int AccW = CODE_W + 7;
  localparam int NW = 6;

  logic [AccW-1:0] acc;
  logic [NW-1:0]   n;
  logic            busy;
  logic            fin;
  logic            out_free;
  logic            emit;
  logic [AccW-1:0] shifted;
  logic [NW-1:0]   n_sub;
  logic [7:0]      cur_byte;

  assign out_free = !out_valid || !out_stall;
  assign q_pop = !busy && q_valid;
  assign emit = !q_pop && busy && out_free && ((n >= NW'(8)) || (fin && n != '0));
  assign n_sub = n - NW'(8);
  assign shifted = acc >> n_sub;
  // pad a partial byte with ones
  assign cur_byte = (n >= NW'(8)) ? shifted[7:0]
                  : ((acc[7:0] << (NW'(8) - n)) | (8'hFF >> n));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      n <= '0;
      acc <= '0;
      fin <= 1'b0;
      out_valid <= 1'b0;
      out_byte <= '0;
      out_last <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        acc <= (acc << q_entry.len) | AccW'(q_entry.code);
        n <= n + NW'(q_entry.len);
        fin <= q_entry.last;
        busy <= 1'b1;
      end else if (busy && out_free) begin
        if (n >= NW'(8)) begin
          out_byte <= cur_byte;
          out_last <= fin && (n == NW'(8));
          if (n_sub < NW'(8) && !(fin && n_sub != '0)) begin
            busy <= 1'b0;
            if (fin) begin
              n <= '0;
              acc <= '0;
            end else begin
              n <= n_sub;
            end
          end else begin
            n <= n_sub;
          end
        end else if (fin && n != '0) begin
          out_byte <= cur_byte;
          out_last <= 1'b1;
          n <= '0;
          acc <= '0;
          busy <= 1'b0;
        end else begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* design/hpack_huffman_encoder_unit.sv */
// top level of the hpack huffman string encoder
`default_nettype none
// Encodes a string one byte per input transfer into RFC 7541 Huffman code,
// emitting output bytes MSB first and padding the tail with ones; out_last
// flags the final byte. A front end looks up each code and queues it; the
// back end drains the accumulator one byte per cycle unless the output
// stalls, through the single-byte output register, and takes a new code
// from the queue only when idle, once the full bytes of the last are out.
module hpack_huffman_encoder_unit
  import hpack_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [SYM_W-1:0] symbol,
  input  wire logic             last,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_last
);
  logic      q_valid;
  logic      q_pop;
  hp_entry_t q_entry;

  hpack_front #(.QueueDepth(QueueDepth)) u_front (
    .clk, .rst, .in_valid, .in_stall, .symbol, .last,
    .q_valid, .q_pop, .q_entry
  );

  hpack_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_entry,
    .out_valid, .out_stall, .out_byte, .out_last
  );
endmodule
`default_nettype wire
